/* src/range_min_stack_store_unit_assert.svh */
// Assertion macros shared by the stack store RTL.
`ifndef RANGE_MIN_STACK_STORE_UNIT_ASSERT_SVH
`define RANGE_MIN_STACK_STORE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checks a condition at every rising clock edge outside reset.
`define RMSS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Checks that a consequent holds in the same cycle as its antecedent.
`define RMSS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define RMSS_ASSERT_ALWAYS(label, cond, msg)
`define RMSS_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

/* src/rmss_pkg.sv */
// Types and constants of the range minimum stack store.
`timescale 1ns / 1ps
package rmss_pkg;
	localparam int DEPTH  = 1024;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = 11;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_POP   = 2'd1,
		FUNC_COUNT = 2'd2,
		FUNC_RANGE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ERR_OK          = 3'd0,
		ERR_RANGE_EMPTY = 3'd1,
		ERR_RANGE_PAST  = 3'd2,
		ERR_POP_EMPTY   = 3'd3,
		ERR_PUSH_FULL   = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;
endpackage

/* src/rmss_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module rmss_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* src/range_min_stack_store_unit.sv */
// Top level of the range minimum stack store: sequencer, count and result register.
`timescale 1ns / 1ps
// The block holds a stack of signed 32-bit values in one synchronous RAM.
// Input words arrive on the s_axis channel; the operation code rides in tuser
// (push, pop, count, range query). Every input word yields exactly one result
// word on the m_axis channel carrying the extreme value, the stack count after
// the word and an error code. cfg_we/cfg_wdata set the ordering: 0 returns the
// minimum of the range, 1 the maximum. Write it only while the block is idle.
// Push, pop, count and any rejected query go from idle through the emit state
// into the output register, and the next word is taken once the sequencer is
// back in idle, so the block takes no new word before the last result is
// registered. A valid range query reads the RAM one entry per cycle through its
// single read port, entries range_start up to range_end - 1, then passes through
// the emit state into the output register; the next word is taken after that.
// A new input word is taken only while the sequencer is idle; the output
// register lets it accept the next word while a result still waits. If the
// receiver stalls, the finished result is held in the output register and
// the next result waits in the sequencer until the register frees up.
// Reset empties the stack and selects minimum ordering; the RAM contents are
// not cleared, since only entries below the count are ever read.
`include "range_min_stack_store_unit_assert.svh"
module range_min_stack_store_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: value[31:0], range_start[42:32], range_end[53:43], zero fill
	input  logic [55:0] s_axis_tdata,
	// tuser: func[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: extreme_value[31:0], count[42:32], error_code[45:43], zero fill
	output logic [47:0] m_axis_tdata
);
	rmss_pkg::state_t state_q, state_d;
	logic             order_q;
	rmss_pkg::cnt_t   count_q;
	rmss_pkg::cnt_t   idx_q;
	rmss_pkg::cnt_t   end_q;
	logic             rvalid_s1;
	logic             first_q;
	rmss_pkg::data_t  best_q;
	rmss_pkg::data_t  res_value_q;
	rmss_pkg::err_t   res_err_q;
	logic             out_valid_q;
	logic [47:0]      out_data_q;

	rmss_pkg::func_t  func_in;
	rmss_pkg::data_t  value_in;
	rmss_pkg::cnt_t   start_in;
	rmss_pkg::cnt_t   end_in;
	logic             in_accept;
	logic             out_free;
	rmss_pkg::err_t   err_in;
	logic             scan_start;
	logic             issue;
	logic             beats;
	rmss_pkg::data_t  best_next;
	rmss_pkg::data_t  rdata;
	logic             ram_we;
	logic             ram_re;
	logic [rmss_pkg::ADDR_W-1:0] ram_raddr;

	assign func_in   = rmss_pkg::func_t'(s_axis_tuser);
	assign value_in  = s_axis_tdata[31:0];
	assign start_in  = s_axis_tdata[42:32];
	assign end_in    = s_axis_tdata[53:43];
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;

	// Decode the word and spot every error before anything is touched.
	always_comb begin
		err_in     = rmss_pkg::ERR_OK;
		scan_start = 1'b0;
		case (func_in)
			rmss_pkg::FUNC_PUSH: begin
				if (count_q >= rmss_pkg::CNT_W'(rmss_pkg::DEPTH)) begin
					err_in = rmss_pkg::ERR_PUSH_FULL;
				end
			end
			rmss_pkg::FUNC_POP: begin
				if (count_q == '0) begin
					err_in = rmss_pkg::ERR_POP_EMPTY;
				end
			end
			rmss_pkg::FUNC_RANGE: begin
				if (start_in >= end_in) begin
					err_in = rmss_pkg::ERR_RANGE_EMPTY;
				end else if (end_in > count_q) begin
					err_in = rmss_pkg::ERR_RANGE_PAST;
				end else begin
					scan_start = 1'b1;
				end
			end
			default: begin
				err_in = rmss_pkg::ERR_OK;
			end
		endcase
	end

	// Compare the entry just read against the running best.
	assign beats     = order_q ? (rdata > best_q) : (rdata < best_q);
	assign best_next = (first_q || beats) ? rdata : best_q;
	assign issue     = idx_q < end_q;

	// Next state and handshake outputs.
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		ram_re        = 1'b0;
		ram_raddr     = idx_q[rmss_pkg::ADDR_W-1:0];
		case (state_q)
			rmss_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				ram_raddr     = start_in[rmss_pkg::ADDR_W-1:0];
				if (s_axis_tvalid) begin
					ram_re  = scan_start;
					state_d = scan_start ? rmss_pkg::ST_SCAN : rmss_pkg::ST_EMIT;
				end
			end
			rmss_pkg::ST_SCAN: begin
				ram_re = issue;
				if (!issue && rvalid_s1) begin
					state_d = rmss_pkg::ST_EMIT;
				end
			end
			rmss_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = rmss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rmss_pkg::ST_IDLE;
			end
		endcase
	end

	assign ram_we = in_accept && (func_in == rmss_pkg::FUNC_PUSH) &&
		(err_in == rmss_pkg::ERR_OK);

	rmss_ram #(
		.ADDR_W(rmss_pkg::ADDR_W),
		.DATA_W(rmss_pkg::DATA_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[rmss_pkg::ADDR_W-1:0]),
		.wdata(value_in),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	// Stack count moves only on an accepted push or pop that is not rejected.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_accept && err_in == rmss_pkg::ERR_OK) begin
			if (func_in == rmss_pkg::FUNC_PUSH) begin
				count_q <= count_q + 1'b1;
			end else if (func_in == rmss_pkg::FUNC_POP) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= ram_re;
		end
	end

	// Scan pointer, running best and pending result.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			idx_q       <= start_in + 1'b1;
			end_q       <= end_in;
			first_q     <= 1'b1;
			res_value_q <= '0;
			res_err_q   <= err_in;
		end else if (state_q == rmss_pkg::ST_SCAN) begin
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rvalid_s1) begin
				best_q  <= best_next;
				first_q <= 1'b0;
				if (!issue) begin
					res_value_q <= best_next;
				end
			end
		end
	end

	// Output register; holds its word while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rmss_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rmss_pkg::ST_EMIT && out_free) begin
			out_data_q <= {2'b00, res_err_q, count_q, res_value_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`RMSS_ASSERT_ALWAYS(a_count_bound, count_q <= rmss_pkg::CNT_W'(rmss_pkg::DEPTH), "count big")
	`RMSS_ASSERT_IMPLY(a_scan_bound, state_q == rmss_pkg::ST_SCAN, idx_q <= end_q, "scan overran")
	`RMSS_ASSERT_IMPLY(a_read_in_scan, rvalid_s1, state_q == rmss_pkg::ST_SCAN, "read outside scan")
	`RMSS_ASSERT_IMPLY(a_count_moves, count_q != $past(count_q), $past(in_accept), "count moved")
	`RMSS_ASSERT_IMPLY(a_scan_in_stack, state_q == rmss_pkg::ST_SCAN, end_q <= count_q, "scan high")
endmodule
